// File: src/assert_macros.svh
// Assertion helpers used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: src/pqdm_pkg.sv
`default_nettype none
package pqdm_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVER  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  typedef logic signed [31:0] pqdm_value_t;

  typedef struct packed {
    logic [1:0]  op;
    pqdm_value_t value;
  } pqdm_in_t;

  typedef struct packed {
    pqdm_value_t value_res;
    logic [1:0]  status;
    logic        empty_res;
    logic [3:0]  count;
  } pqdm_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec_short;
    logic scan;
    logic shift;
    logic emit;
  } pqdm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_delete;
    logic empty;
    logic scan_last;
    logic out_free;
  } pqdm_sts_t;

  // The reported count is the low four bits of the fill level.
  function automatic logic [3:0] cnt_to_res(input logic [CNT_W-1:0] c);
    logic [CNT_W+3:0] w;
    w = {4'b0000, c};
    return w[3:0];
  endfunction

endpackage
`default_nettype wire

// File: src/priority_queue_delete_max.sv
// Insert, peek, unused op codes and a delete on an empty queue pass from the accept
// through a decide state to the emit state, which registers the result once the
// output is free. Delete-max on count entries instead scans them for the largest:
// the scan reads one entry per cycle, then a shift state closes the gap. The output
// register lets the next transaction enter.
// Reset (rst_n low, synchronous) empties the queue; stored values are not cleared.
`default_nettype none
module priority_queue_delete_max
  import pqdm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  pqdm_in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output pqdm_out_t out_data
);

  pqdm_cmd_t cmd;
  pqdm_sts_t sts;

  pqdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pqdm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: src/pqdm_ctrl.sv
`default_nettype none
module pqdm_ctrl
  import pqdm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  pqdm_sts_t sts,
  output pqdm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.op_delete && !sts.empty) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.exec_short = 1'b1;
          state_nxt      = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/pqdm_dp.sv
`default_nettype none
`include "assert_macros.svh"
module pqdm_dp
  import pqdm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  pqdm_in_t  in_data,
  input  pqdm_cmd_t cmd,
  output pqdm_sts_t sts,
  output logic      out_valid,
  input  wire logic out_ready,
  output pqdm_out_t out_data
);

  pqdm_value_t      entries_r [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_r;
  logic [IDX_W-1:0] pos_r;
  pqdm_value_t      best_r;
  logic [1:0]       op_r;
  pqdm_value_t      value_r;
  pqdm_value_t      res_r;
  logic [1:0]       st_r;
  logic             out_valid_r;
  pqdm_out_t        out_data_r;
  pqdm_value_t      scan_val;

  assign scan_val      = entries_r[scan_r[IDX_W-1:0]];
  assign sts.op_delete = (op_r == OP_DELETE);
  assign sts.empty     = (count_r == '0);
  assign sts.scan_last = ((scan_r + CNT_W'(1)) == count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      value_r <= in_data.value;
      scan_r  <= '0;
    end

    if (cmd.exec_short) begin
      unique case (op_r)
        OP_INSERT: begin
          res_r <= '0;
          if (count_r >= CNT_W'(DEPTH)) begin
            st_r <= ST_OVER;
          end else begin
            st_r <= ST_OK;
            entries_r[count_r[IDX_W-1:0]] <= value_r;
          end
        end
        OP_DELETE: begin
          res_r <= '0;
          st_r  <= ST_UNDER;
        end
        OP_PEEK: begin
          if (count_r == '0) begin
            res_r <= '0;
            st_r  <= ST_UNDER;
          end else begin
            res_r <= entries_r[0];
            st_r  <= ST_OK;
          end
        end
        default: begin
          res_r <= '0;
          st_r  <= ST_OK;
        end
      endcase
    end

    // The scan keeps the first of equal maxima: only a strictly larger value wins.
    if (cmd.scan) begin
      if (scan_r == '0 || scan_val > best_r) begin
        best_r <= scan_val;
        pos_r  <= scan_r[IDX_W-1:0];
      end
      scan_r <= scan_r + CNT_W'(1);
    end

    if (cmd.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDX_W'(i) >= pos_r) begin
          entries_r[i] <= entries_r[i+1];
        end
      end
      res_r <= best_r;
      st_r  <= ST_OK;
    end

    if (cmd.emit) begin
      out_data_r.value_res <= res_r;
      out_data_r.status    <= st_r;
      out_data_r.empty_res <= (count_r == '0);
      out_data_r.count     <= cnt_to_res(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec_short && op_r == OP_INSERT && count_r < CNT_W'(DEPTH)) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.shift) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ASSERT_NEVER(a_count_bound, count_r > CNT_W'(DEPTH), "fill level above depth")
  `ASSERT_CLK(a_emit_free, cmd.emit |-> (!out_valid_r || out_ready), "result overwritten")
  `ASSERT_CLK(a_shift_nonempty, cmd.shift |-> (count_r != '0), "shift on empty queue")
  `ASSERT_CLK(a_scan_range, cmd.scan |-> (scan_r < count_r), "scan past fill level")

endmodule
`default_nettype wire
